// File: sv/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the LZ window decompressor: transaction
// payloads and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

	localparam int          HIST_DEPTH  = 8192;
	localparam int          PTR_W       = 13;
	localparam int          FILL_W      = 14;
	localparam int          LANES       = 4;
	localparam int          LANE_W      = 3;
	localparam int          CNT_W       = 9;
	localparam logic [13:0] WINDOW_SIZE = 14'd8192;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} lzwd_in_t;

	typedef struct packed {
		logic [7:0] out_byte0;
		logic [7:0] out_byte1;
		logic [7:0] out_byte2;
		logic [7:0] out_byte3;
		logic [2:0] out_count;
		logic       out_last;
		logic       out_truncated;
	} lzwd_out_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;     // input transaction taken, decode the byte
		logic rd;       // read one history byte for a copy
		logic put;      // store the copied byte
		logic fin;      // close the step, emit what is pending
	} lzwd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic copy;        // byte at the input starts a back-reference copy
		logic lanes_full;  // lane buffer holds a full group
		logic cnt_last;    // one byte of the copy remains
		logic need_emit;   // closing the step produces a result
		logic out_free;    // output register can load this cycle
	} lzwd_sts_t;

endpackage

`default_nettype wire

// File: sv/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Step sequencer: takes one compressed byte, walks the copy loop one
// history read and one write at a time, then closes the step.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_ctrl
	import lzwd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      comp_valid,
	output logic           comp_stall,
	input  wire lzwd_sts_t sts,
	output lzwd_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WR   = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign comp_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (comp_valid) begin
					cmd.exec = 1'b1;
					state_d  = sts.copy ? S_RD : S_FIN;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				// hold while a full group cannot leave
				if (!sts.lanes_full || sts.out_free) begin
					cmd.put = 1'b1;
					state_d = sts.cnt_last ? S_FIN : S_RD;
				end
			end
			S_FIN: begin
				if (!sts.need_emit || sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_put_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put |-> ($past(cmd.rd) || $past(state_q == S_WR)))
		else $error("copy byte stored without a history read");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && sts.need_emit) |-> sts.out_free)
		else $error("step closed while output register busy");

	a_exec_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == S_RD || state_q == S_FIN))
		else $error("accepted byte did not start work");

endmodule

`default_nettype wire

// File: sv/lzwd_dp.sv
// ----------------------------------------------------------------------------
// lzwd_dp
// Datapath: flag word and token parser, 8 KiB history memory, copy
// counter, four-lane packer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_dp
	import lzwd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire lzwd_in_t  comp_data,
	input  wire lzwd_cmd_t cmd,
	output lzwd_sts_t      sts,
	output logic           plain_valid,
	input  wire logic      plain_stall,
	output lzwd_out_t      plain_data
);

	localparam logic [2:0] PH_FLAG_LO    = 3'd0;
	localparam logic [2:0] PH_FLAG_HI    = 3'd1;
	localparam logic [2:0] PH_TOKEN      = 3'd2;
	localparam logic [2:0] PH_B2         = 3'd3;
	localparam logic [2:0] PH_EXTRA_NEAR = 3'd4;
	localparam logic [2:0] PH_EXTRA_FAR  = 3'd5;

	// parser state
	logic [2:0]        phase_q, phase_d;
	logic [15:0]       flag_q, flag_d;
	logic [4:0]        bits_q, bits_d;
	logic [7:0]        b1_q, b1_d;
	logic [7:0]        b2_q, b2_d;
	logic              done_q;
	logic              last_q, term_q, skip_q;

	// copy and history state
	logic [PTR_W-1:0]  wp_q;
	logic [FILL_W-1:0] bw_q;
	logic [FILL_W-1:0] dist_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        hist_mem [HIST_DEPTH];
	logic [7:0]        rd_q;
	logic              zero_q;

	// lane packer and output
	logic [7:0]        lane_q [LANES];
	logic [LANE_W-1:0] fill_q;
	logic              out_valid_q;
	lzwd_out_t         out_q;

	// decode
	logic              lit, copy, term, skip;
	logic [CNT_W-1:0]  cnt_d;
	logic [PTR_W-1:0]  off;
	logic [FILL_W-1:0] back_dist;
	logic [4:0]        bits_dec;
	logic [2:0]        tok_next;
	logic [7:0]        b;

	logic              put_en;
	logic [7:0]        put_data;
	logic              emit_full, emit_fin, load;
	logic              restart;
	lzwd_out_t         load_data;

	assign b        = comp_data.in_byte;
	assign bits_dec = bits_q - {4'd0, (bits_q != 5'd0)};
	assign tok_next = (bits_q == 5'd0) ? PH_FLAG_LO : PH_TOKEN;

	always_comb begin
		phase_d = phase_q;
		flag_d  = flag_q;
		bits_d  = bits_q;
		b1_d    = b1_q;
		b2_d    = b2_q;
		lit     = 1'b0;
		copy    = 1'b0;
		term    = 1'b0;
		skip    = 1'b0;
		cnt_d   = '0;
		off     = '0;
		if (done_q) begin
			skip = 1'b1;
		end else begin
			case (phase_q)
				PH_FLAG_LO: begin
					flag_d  = {8'd0, b};
					phase_d = PH_FLAG_HI;
				end
				PH_FLAG_HI: begin
					flag_d  = {b, flag_q[7:0]};
					bits_d  = 5'd16;
					phase_d = PH_TOKEN;
				end
				PH_TOKEN: begin
					flag_d = {1'b0, flag_q[15:1]};
					bits_d = bits_dec;
					if (flag_q[0]) begin
						lit     = 1'b1;
						phase_d = (bits_dec == 5'd0) ? PH_FLAG_LO : PH_TOKEN;
					end else begin
						b1_d    = b;
						phase_d = PH_B2;
					end
				end
				PH_B2: begin
					b2_d = b;
					if ((b & 8'hE0) != 8'd0) begin
						if (b[2:0] == 3'd0) begin
							phase_d = PH_EXTRA_NEAR;
						end else begin
							copy    = 1'b1;
							off     = {b[7:3], b1_q};
							cnt_d   = {6'd0, b[2:0]} + 9'd2;
							phase_d = tok_next;
						end
					end else if (b1_q == 8'd0 && b == 8'd0) begin
						term = 1'b1;
					end else begin
						phase_d = PH_EXTRA_FAR;
					end
				end
				PH_EXTRA_NEAR: begin
					if (b == 8'd0) begin
						term = 1'b1;
					end else begin
						copy    = 1'b1;
						off     = {b2_q[7:3], b1_q};
						cnt_d   = {1'b0, b} + 9'd1;
						phase_d = tok_next;
					end
				end
				PH_EXTRA_FAR: begin
					copy    = 1'b1;
					off     = {b2_q[4:0], b1_q};
					cnt_d   = {1'b0, b} + 9'd1;
					phase_d = tok_next;
				end
				default: phase_d = PH_FLAG_LO;
			endcase
		end
	end

	assign back_dist = WINDOW_SIZE - {1'b0, off};

	assign put_en   = (cmd.exec && lit) || cmd.put;
	assign put_data = cmd.exec ? b : (zero_q ? 8'd0 : rd_q);
	assign restart  = cmd.fin && last_q;

	assign sts.copy       = copy;
	assign sts.lanes_full = (fill_q == 3'(LANES));
	assign sts.cnt_last   = (cnt_q == 9'd1);
	assign sts.need_emit  = !skip_q && (term_q || last_q || fill_q != '0);
	assign sts.out_free   = !out_valid_q || !plain_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG_LO;
			flag_q  <= '0;
			bits_q  <= '0;
			b1_q    <= '0;
			b2_q    <= '0;
			done_q  <= 1'b0;
			last_q  <= 1'b0;
			term_q  <= 1'b0;
			skip_q  <= 1'b0;
		end else begin
			if (cmd.exec) begin
				phase_q <= phase_d;
				flag_q  <= flag_d;
				bits_q  <= bits_d;
				b1_q    <= b1_d;
				b2_q    <= b2_d;
				last_q  <= comp_data.in_last;
				term_q  <= term;
				skip_q  <= skip;
			end
			if (restart) begin
				phase_q <= PH_FLAG_LO;
				flag_q  <= '0;
				bits_q  <= '0;
				b1_q    <= '0;
				b2_q    <= '0;
				done_q  <= 1'b0;
			end else if (cmd.fin && term_q && !skip_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			bw_q   <= '0;
			cnt_q  <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.exec && copy) begin
				cnt_q <= cnt_d;
			end else if (cmd.put) begin
				cnt_q <= cnt_q - 9'd1;
			end
			if (restart) begin
				wp_q <= '0;
				bw_q <= '0;
			end else if (put_en) begin
				wp_q <= wp_q + 13'd1;
				if (bw_q != WINDOW_SIZE) begin
					bw_q <= bw_q + 14'd1;
				end
			end
			if (cmd.fin) begin
				fill_q <= '0;
			end else if (put_en) begin
				fill_q <= sts.lanes_full ? 3'd1 : fill_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && copy) begin
			dist_q <= back_dist;
		end
		if (put_en) begin
			if (sts.lanes_full) begin
				lane_q[0] <= put_data;
			end else begin
				lane_q[fill_q[1:0]] <= put_data;
			end
		end
	end

	// history: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (put_en) begin
			hist_mem[wp_q] <= put_data;
		end
		if (cmd.rd) begin
			rd_q   <= hist_mem[wp_q - dist_q[PTR_W-1:0]];
			zero_q <= (bw_q < dist_q);
		end
	end

	assign emit_full = cmd.put && sts.lanes_full;
	assign emit_fin  = cmd.fin && sts.need_emit;
	assign load      = emit_full || emit_fin;

	always_comb begin
		if (emit_full) begin
			load_data.out_count     = 3'(LANES);
			load_data.out_last      = 1'b0;
			load_data.out_truncated = 1'b0;
		end else begin
			load_data.out_count     = fill_q;
			load_data.out_last      = term_q || last_q;
			load_data.out_truncated = last_q && !term_q;
		end
		load_data.out_byte0 = (load_data.out_count > 3'd0) ? lane_q[0] : 8'd0;
		load_data.out_byte1 = (load_data.out_count > 3'd1) ? lane_q[1] : 8'd0;
		load_data.out_byte2 = (load_data.out_count > 3'd2) ? lane_q[2] : 8'd0;
		load_data.out_byte3 = (load_data.out_count > 3'd3) ? lane_q[3] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!plain_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_data;
		end
	end

	assign plain_valid = out_valid_q;
	assign plain_data  = out_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 3'(LANES))
		else $error("lane fill out of range");

	a_bw_sat: assert property (@(posedge clk) disable iff (!arst_n)
		bw_q <= WINDOW_SIZE)
		else $error("history fill count past window");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> sts.out_free)
		else $error("result loaded over a pending one");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_data.out_count == 3'd0) |-> load_data.out_last)
		else $error("empty result not marked last");

endmodule

`default_nettype wire

// File: sv/lz_window_decompressor_top.sv
// ----------------------------------------------------------------------------
// lz_window_decompressor_top
// LZ77-style decompressor with an 8 KiB window: one compressed byte per
// transaction in, groups of up to four decompressed bytes out.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload     direction
//   comp      comp_valid/comp_stall   lzwd_in_t   into the block
//   plain     plain_valid/plain_stall lzwd_out_t  out of the block
//
// A flag, literal or token byte is decoded, then its step is closed. A byte
// that starts a copy of N bytes runs the copy loop in between: each copied
// byte is a history read, then a write, on the 8192 x 8 history memory.
// Reset clears the parser, the history fill count and the output valid flag;
// the history memory itself is not cleared.
// A stall on plain holds the block where a result is due; comp_stall is
// high whenever a byte is still being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module lz_window_decompressor_top
	import lzwd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      comp_valid,
	output logic           comp_stall,
	input  wire lzwd_in_t  comp_data,
	output logic           plain_valid,
	input  wire logic      plain_stall,
	output lzwd_out_t      plain_data
);

	lzwd_cmd_t cmd;
	lzwd_sts_t sts;

	lzwd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.comp_valid (comp_valid),
		.comp_stall (comp_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	lzwd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.comp_data   (comp_data),
		.cmd         (cmd),
		.sts         (sts),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.plain_data  (plain_data)
	);

endmodule

`default_nettype wire
